// ===== rtl/lssp_pkg.sv =====
package lssp_pkg;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_DEL   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_HOP     = 2'd1,
    ST_UNREACH = 2'd2,
    ST_REJECT  = 2'd3
  } status_e;

  localparam int unsigned Nodes = 16;
  localparam int unsigned NodeW = 4;
  localparam int unsigned CostW = 16;
  localparam int unsigned PathW = 20;
  localparam int unsigned MaxHops = 16;

endpackage

// ===== rtl/lssp_core.sv =====
module lssp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 cmd_i,
  input  logic [lssp_pkg::NodeW-1:0] node_a_i,
  input  logic [lssp_pkg::NodeW-1:0] node_b_i,
  input  logic [lssp_pkg::CostW-1:0] link_cost_i,
  output logic                       valid_o,
  output logic [1:0]                 status_o,
  output logic [lssp_pkg::NodeW-1:0] hop_node_o,
  output logic [lssp_pkg::NodeW-1:0] next_hop_o,
  output logic [lssp_pkg::PathW-1:0] path_cost_o,
  output logic                       last_o
);

  localparam int unsigned NW = lssp_pkg::NodeW;
  localparam int unsigned AW = 2 * NW;
  localparam int unsigned CW = NW + 1;
  localparam int unsigned KW = lssp_pkg::CostW;
  localparam int unsigned PW = lssp_pkg::PathW;
  localparam int unsigned RW = PW + 2 * NW;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_WR2   = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_PICK  = 9'b000010000,
    S_RELAX = 9'b000100000,
    S_TRACE = 9'b001000000,
    S_TRW   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Link matrix memory, cleared by a pass after reset.
  logic [KW-1:0] lw_mem [lssp_pkg::Nodes*lssp_pkg::Nodes];
  logic [KW-1:0] lw_rd_q, lw_wd;
  logic [AW-1:0] lw_ra, lw_wa;
  logic          lw_we;

  // Per-node record memory: cost, previous node, first hop.
  logic [RW-1:0] nd_mem [lssp_pkg::Nodes];
  logic [RW-1:0] nd_rd_q, nd_wd;
  logic [NW-1:0] nd_ra, nd_wa;
  logic          nd_we;

  logic [lssp_pkg::Nodes-1:0] known_q, known_d, reached_q, reached_d, done_q, done_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [NW-1:0] a_q, a_d, b_q, b_d, best_q, best_d, bfh_q, bfh_d, dfh_q, dfh_d;
  logic [KW-1:0] cost_q, cost_d;
  logic [CW-1:0] cnt_q, cnt_d, nhop_q, nhop_d;
  logic          found_q, found_d;
  logic [PW-1:0] bcost_q, bcost_d, dcost_q, dcost_d;
  logic [NW-1:0] path_q [lssp_pkg::Nodes];
  logic [NW-1:0] path_d [lssp_pkg::Nodes];
  logic          out_v_q, out_v_d, out_l_q, out_l_d;
  logic [1:0]    out_s_q, out_s_d;
  logic [NW-1:0] out_h_q, out_h_d, out_n_q, out_n_d;
  logic [PW-1:0] out_c_q, out_c_d;

  logic [PW-1:0] rd_cost, nc;
  logic [NW-1:0] rd_pred, rd_fh, idx, pidx, nh;
  logic [KW-1:0] set_cost;
  logic          link_ok, query_ok, scan_hit, rlx_upd;

  assign rd_cost  = nd_rd_q[RW-1 -: PW];
  assign rd_pred  = nd_rd_q[2*NW-1 -: NW];
  assign rd_fh    = nd_rd_q[NW-1:0];
  assign idx      = cnt_q[NW-1:0] - NW'(1);
  assign pidx     = nhop_q[NW-1:0] - NW'(1);
  assign nc       = bcost_q + PW'(lw_rd_q);
  assign nh       = (best_q == a_q) ? idx : bfh_q;
  assign set_cost = (cmd_i == lssp_pkg::CMD_SET) ? link_cost_i : '0;
  assign link_ok  = (cmd_i == lssp_pkg::CMD_SET || cmd_i == lssp_pkg::CMD_DEL)
                    && node_a_i != node_b_i;
  assign query_ok = (cmd_i == lssp_pkg::CMD_QUERY) && known_q[node_a_i];
  assign scan_hit = cnt_q != '0 && reached_q[idx] && !done_q[idx]
                    && (!found_q || rd_cost < bcost_q);
  assign rlx_upd  = cnt_q != '0 && lw_rd_q != '0 && !done_q[idx]
                    && (!reached_q[idx] || nc < rd_cost
                        || (nc == rd_cost && best_q < rd_pred));

  always_ff @(posedge clk_i) begin
    if (lw_we) begin
      lw_mem[lw_wa] <= lw_wd;
    end
    lw_rd_q <= lw_mem[lw_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nd_we) begin
      nd_mem[nd_wa] <= nd_wd;
    end
    nd_rd_q <= nd_mem[nd_ra];
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    a_d       = a_q;
    b_d       = b_q;
    cost_d    = cost_q;
    known_d   = known_q;
    reached_d = reached_q;
    done_d    = done_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    best_d    = best_q;
    bcost_d   = bcost_q;
    bfh_d     = bfh_q;
    nhop_d    = nhop_q;
    dcost_d   = dcost_q;
    dfh_d     = dfh_q;
    path_d    = path_q;
    out_v_d   = 1'b0;
    out_s_d   = out_s_q;
    out_h_d   = out_h_q;
    out_n_d   = out_n_q;
    out_c_d   = out_c_q;
    out_l_d   = out_l_q;
    lw_we     = 1'b0;
    lw_wa     = {a_q, b_q};
    lw_wd     = cost_q;
    lw_ra     = {best_q, cnt_q[NW-1:0]};
    nd_we     = 1'b0;
    nd_wa     = idx;
    nd_wd     = {nc, best_q, nh};
    nd_ra     = cnt_q[NW-1:0];
    unique case (state_q)
      S_CLR: begin
        lw_we = 1'b1;
        lw_wa = clr_q;
        lw_wd = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        lw_wa = {node_a_i, node_b_i};
        lw_wd = set_cost;
        nd_wa = node_a_i;
        nd_wd = {PW'(0), node_a_i, node_a_i};
        if (start_i) begin
          a_d     = node_a_i;
          b_d     = node_b_i;
          cost_d  = set_cost;
          cnt_d   = '0;
          found_d = 1'b0;
          out_s_d = lssp_pkg::ST_UPDATED;
          out_h_d = '0;
          out_n_d = '0;
          out_c_d = '0;
          out_l_d = 1'b1;
          if (link_ok) begin
            lw_we             = 1'b1;
            known_d[node_a_i] = 1'b1;
            known_d[node_b_i] = 1'b1;
            out_v_d           = 1'b1;
            state_d           = S_WR2;
          end else if (query_ok) begin
            nd_we               = 1'b1;
            reached_d           = '0;
            reached_d[node_a_i] = 1'b1;
            done_d              = '0;
            state_d             = S_SCAN;
          end else if (cmd_i == lssp_pkg::CMD_QUERY) begin
            out_v_d = 1'b1;
            out_s_d = lssp_pkg::ST_UNREACH;
          end else if (cmd_i != lssp_pkg::CMD_NONE) begin
            out_v_d = 1'b1;
            out_s_d = lssp_pkg::ST_REJECT;
          end
        end
      end
      S_WR2: begin
        lw_we   = 1'b1;
        lw_wa   = {b_q, a_q};
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (scan_hit) begin
          found_d = 1'b1;
          best_d  = idx;
          bcost_d = rd_cost;
          bfh_d   = rd_fh;
        end
        if (cnt_q == CW'(lssp_pkg::Nodes)) begin
          cnt_d   = '0;
          state_d = (found_q || scan_hit) ? S_PICK : S_TRACE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_PICK: begin
        done_d[best_q] = 1'b1;
        state_d        = S_RELAX;
      end
      S_RELAX: begin
        if (rlx_upd) begin
          nd_we          = 1'b1;
          reached_d[idx] = 1'b1;
        end
        if (cnt_q == CW'(lssp_pkg::Nodes)) begin
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_TRACE: begin
        nd_ra  = b_q;
        nhop_d = '0;
        if (reached_q[b_q]) begin
          state_d = S_TRW;
        end else begin
          out_v_d = 1'b1;
          out_s_d = lssp_pkg::ST_UNREACH;
          out_h_d = '0;
          out_n_d = '0;
          out_c_d = '0;
          out_l_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TRW: begin
        nd_ra                       = rd_pred;
        path_d[nhop_q[NW-1:0]]      = rd_pred;
        nhop_d                      = nhop_q + CW'(1);
        if (nhop_q == '0) begin
          dcost_d = rd_cost;
          dfh_d   = rd_fh;
        end
        if (rd_pred == a_q || nhop_q == CW'(lssp_pkg::MaxHops - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        out_v_d = 1'b1;
        out_s_d = lssp_pkg::ST_HOP;
        out_h_d = path_q[pidx];
        out_n_d = dfh_q;
        out_c_d = dcost_q;
        out_l_d = (nhop_q == CW'(1));
        nhop_d  = nhop_q - CW'(1);
        if (nhop_q == CW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      a_q       <= '0;
      b_q       <= '0;
      cost_q    <= '0;
      known_q   <= '0;
      reached_q <= '0;
      done_q    <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      best_q    <= '0;
      bcost_q   <= '0;
      bfh_q     <= '0;
      nhop_q    <= '0;
      dcost_q   <= '0;
      dfh_q     <= '0;
      path_q    <= '{default: '0};
      out_v_q   <= 1'b0;
      out_s_q   <= '0;
      out_h_q   <= '0;
      out_n_q   <= '0;
      out_c_q   <= '0;
      out_l_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      a_q       <= a_d;
      b_q       <= b_d;
      cost_q    <= cost_d;
      known_q   <= known_d;
      reached_q <= reached_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      best_q    <= best_d;
      bcost_q   <= bcost_d;
      bfh_q     <= bfh_d;
      nhop_q    <= nhop_d;
      dcost_q   <= dcost_d;
      dfh_q     <= dfh_d;
      path_q    <= path_d;
      out_v_q   <= out_v_d;
      out_s_q   <= out_s_d;
      out_h_q   <= out_h_d;
      out_n_q   <= out_n_d;
      out_c_q   <= out_c_d;
      out_l_q   <= out_l_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign valid_o     = out_v_q;
  assign status_o    = out_s_q;
  assign hop_node_o  = out_h_q;
  assign next_hop_o  = out_n_q;
  assign path_cost_o = out_c_q;
  assign last_o      = out_l_q;

endmodule

// ===== rtl/link_state_shortest_path.sv =====
// Link-state shortest path engine over 16 routers.
// Commands enter on start_i when busy_o is low: set link, remove link, route query.
// Each result appears for one cycle with valid_o high; last_o marks the final
// result of a command. The receiver cannot stall the block.
// A link command answers in the cycle after it is taken and keeps busy_o high
// while the mirrored entry is written in S_WR2.
// A rejected command or a query from an unknown source answers in the next
// cycle and the next item can be taken at the following edge.
// A query runs one round per reachable router: a scan of the node record
// memory, a pick step and a relax pass over the link memory. A final scan and
// the trace state follow, then the path is traced one hop at a time in S_TRW
// and the hop results are emitted back to back in S_EMIT.
// An unreachable destination answers in the cycle after the trace state.
// After reset all 256 link memory entries are cleared, one entry a cycle,
// while busy_o stays high.
module link_state_shortest_path (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  node_a_i,
  input  logic [3:0]  node_b_i,
  input  logic [15:0] link_cost_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [3:0]  hop_node_o,
  output logic [3:0]  next_hop_o,
  output logic [19:0] path_cost_o,
  output logic        last_o
);

  lssp_core u_core (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .node_a_i, .node_b_i,
    .link_cost_i, .valid_o, .status_o, .hop_node_o, .next_hop_o,
    .path_cost_o, .last_o
  );

endmodule

// ===== test/tb_link_state_shortest_path.sv =====
`timescale 1ns / 100ps

module tb_link_state_shortest_path;

  localparam int unsigned Routers = lssp_pkg::Nodes;
  localparam int unsigned StallLimit = 50000;

  typedef struct packed {
    lssp_pkg::status_e               status;
    logic [lssp_pkg::NodeW-1:0]      hop_node;
    logic [lssp_pkg::NodeW-1:0]      next_hop;
    logic [lssp_pkg::PathW-1:0]      path_cost;
    logic                            last;
  } route_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        cmd_i = lssp_pkg::CMD_NONE;
  logic [3:0]        node_a_i = '0;
  logic [3:0]        node_b_i = '0;
  logic [15:0]       link_cost_i = '0;
  logic              valid_o;
  logic [1:0]        status_o;
  logic [3:0]        hop_node_o;
  logic [3:0]        next_hop_o;
  logic [19:0]       path_cost_o;
  logic              last_o;

  logic [lssp_pkg::CostW-1:0] link_w [Routers][Routers];
  logic              known [Routers];
  route_res_t        pending_routes [$];
  int                errors = 0;
  int                stall_cycles = 0;
  bit                idling_on = 1'b1;

  link_state_shortest_path DUT (.*);

  always #2 clk_i = ~clk_i;

  function automatic route_res_t mk_res(lssp_pkg::status_e st, logic [3:0] hop,
                                        logic [3:0] nh, logic [19:0] cost, logic last);
    route_res_t r;
    r.status = st;
    r.hop_node = hop;
    r.next_hop = nh;
    r.path_cost = cost;
    r.last = last;
    return r;
  endfunction

  function automatic void add_expected(route_res_t r);
    pending_routes = {pending_routes, r};
  endfunction

  task automatic predict_route(input logic [3:0] src, input logic [3:0] dst);
    logic [19:0] cost [Routers];
    logic [3:0]  pred [Routers];
    logic [3:0]  first [Routers];
    bit          reached [Routers];
    bit          settled [Routers];
    logic [3:0]  chain [$];
    logic [3:0]  cur;
    logic [19:0] nc;
    logic [3:0]  nh;
    int          u;
    bit          found;
    if (!known[src]) begin
      add_expected(mk_res(lssp_pkg::ST_UNREACH, '0, '0, '0, 1'b1));
      return;
    end
    foreach (reached[i]) begin
      reached[i] = 1'b0;
      settled[i] = 1'b0;
    end
    reached[src] = 1'b1;
    cost[src] = '0;
    pred[src] = src;
    first[src] = src;
    for (int r = 0; r < Routers; r++) begin
      found = 1'b0;
      u = 0;
      for (int v = 0; v < Routers; v++) begin
        if (reached[v] && !settled[v] && (!found || cost[v] < cost[u])) begin
          u = v;
          found = 1'b1;
        end
      end
      if (!found) break;
      settled[u] = 1'b1;
      for (int v = 0; v < Routers; v++) begin
        if (link_w[u][v] == 0 || settled[v]) continue;
        nc = cost[u] + link_w[u][v];
        nh = (u == src) ? 4'(v) : first[u];
        if (!reached[v] || nc < cost[v] || (nc == cost[v] && 4'(u) < pred[v])) begin
          reached[v] = 1'b1;
          cost[v] = nc;
          pred[v] = 4'(u);
          first[v] = nh;
        end
      end
    end
    if (!reached[dst]) begin
      add_expected(mk_res(lssp_pkg::ST_UNREACH, '0, '0, '0, 1'b1));
      return;
    end
    cur = dst;
    do begin
      cur = pred[cur];
      chain.push_front(cur);
    end while (cur != src && chain.size() < lssp_pkg::MaxHops);
    foreach (chain[k]) begin
      add_expected(mk_res(lssp_pkg::ST_HOP, chain[k], first[dst], cost[dst],
                          k == chain.size() - 1));
    end
  endtask

  task automatic predict_item(input lssp_pkg::cmd_e cmd, input logic [3:0] a,
                              input logic [3:0] b, input logic [15:0] cost);
    case (cmd)
      lssp_pkg::CMD_QUERY: predict_route(a, b);
      lssp_pkg::CMD_NONE: ;
      default: begin
        if (a == b) begin
          add_expected(mk_res(lssp_pkg::ST_REJECT, '0, '0, '0, 1'b1));
        end else begin
          link_w[a][b] = (cmd == lssp_pkg::CMD_DEL) ? '0 : cost;
          link_w[b][a] = (cmd == lssp_pkg::CMD_DEL) ? '0 : cost;
          known[a] = 1'b1;
          known[b] = 1'b1;
          add_expected(mk_res(lssp_pkg::ST_UPDATED, '0, '0, '0, 1'b1));
        end
      end
    endcase
  endtask

  task automatic send_item(input lssp_pkg::cmd_e cmd, input logic [3:0] a,
                           input logic [3:0] b, input logic [15:0] cost);
    start_i <= 1'b1;
    cmd_i <= cmd;
    node_a_i <= a;
    node_b_i <= b;
    link_cost_i <= cost;
    do @(posedge clk_i); while (busy_o);
    predict_item(cmd, a, b, cost);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_routes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(lssp_pkg::CMD_QUERY, 4'd0, 4'd0, 16'd7);
    send_item(lssp_pkg::CMD_SET, 4'd3, 4'd3, 16'd5);
    send_item(lssp_pkg::CMD_DEL, 4'd5, 4'd5, 16'd0);
    send_item(lssp_pkg::CMD_NONE, 4'd1, 4'd2, 16'd3);
    for (int i = 0; i < 15; i++) begin
      send_item(lssp_pkg::CMD_SET, 4'(i), 4'(i + 1), 16'hFFFF);
    end
    send_item(lssp_pkg::CMD_QUERY, 4'd0, 4'd15, 16'd0);
    send_item(lssp_pkg::CMD_QUERY, 4'd15, 4'd0, 16'd0);
    send_item(lssp_pkg::CMD_QUERY, 4'd7, 4'd7, 16'd0);
    send_item(lssp_pkg::CMD_SET, 4'd15, 4'd0, 16'd1);
    send_item(lssp_pkg::CMD_QUERY, 4'd0, 4'd15, 16'd0);
    send_item(lssp_pkg::CMD_SET, 4'd0, 4'd15, 16'd0);
    send_item(lssp_pkg::CMD_DEL, 4'd7, 4'd8, 16'hFFFF);
    send_item(lssp_pkg::CMD_QUERY, 4'd2, 4'd12, 16'd0);
  endtask

  task automatic random_items(input int count);
    int   pick;
    logic [15:0] cost;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      cost = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
      if (pick < 55) begin
        send_item(lssp_pkg::CMD_SET, 4'($urandom), 4'($urandom), cost);
      end else if (pick < 65) begin
        send_item(lssp_pkg::CMD_DEL, 4'($urandom), 4'($urandom), 16'($urandom));
      end else if (pick < 97) begin
        send_item(lssp_pkg::CMD_QUERY, 4'($urandom), 4'($urandom), 16'($urandom));
      end else begin
        send_item(lssp_pkg::CMD_NONE, 4'($urandom), 4'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_random_topology();
    random_items(150);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    random_items(80);
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    random_items(100);
  endtask

  always @(posedge clk_i) begin
    route_res_t exp_r;
    if (rst_ni && valid_o) begin
      if (pending_routes.size() == 0) begin
        $error("unexpected result: status %0d hop %0d", status_o, hop_node_o);
        errors++;
      end else begin
        exp_r = pending_routes.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          errors++;
        end
        if (hop_node_o !== exp_r.hop_node) begin
          $error("hop_node: expected %0d, got %0d", exp_r.hop_node, hop_node_o);
          errors++;
        end
        if (next_hop_o !== exp_r.next_hop) begin
          $error("next_hop: expected %0d, got %0d", exp_r.next_hop, next_hop_o);
          errors++;
        end
        if (path_cost_o !== exp_r.path_cost) begin
          $error("path_cost: expected %0d, got %0d", exp_r.path_cost, path_cost_o);
          errors++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (link_w[i, j]) link_w[i][j] = '0;
    foreach (known[i]) known[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_topology();
    test_drain_pause();
    test_back_to_back();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
